### src/pcdp_pkg.sv
// Package for the partition count block: table geometry, loop constants
// and the read-beat record passed from the sequencer to the datapath.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package pcdp_pkg;

    localparam int MAX_N      = 255;
    localparam int IDX_W      = $clog2(MAX_N + 1);
    localparam int ADDR_W     = 2 * IDX_W;
    localparam int TABLE_DEPTH = 1 << ADDR_W;
    localparam int CNT_W      = 63;
    localparam int IN_W       = 8;

    // First row and first column that the fill pass computes
    localparam int FIRST_FILL_ROW = 3;
    localparam int FIRST_FILL_COL = 2;

    typedef logic [IDX_W-1:0]  idx_t;
    typedef logic [ADDR_W-1:0] addr_t;
    typedef logic [CNT_W-1:0]  cnt_t;

    // One table term to be read and added
    typedef struct packed {
        logic  valid;
        logic  seed;       // term is a seeded one: value 1, memory not used
        logic  first;      // first term of a sum
        logic  last;       // last term of a sum
        logic  final_sum;  // the sum is the row total, i.e. the result
        addr_t rd_addr;
        addr_t wr_addr;    // entry that receives the finished sum
    } beat_t;

endpackage
`default_nettype wire

### src/partition_count_dp_unit.sv
// Top level of the partition count block: accepts a cube count, fills the
// count table in pcdp_ram under control of pcdp_seq and returns p(n).
// Depends on pcdp_pkg, pcdp_ram and pcdp_seq.
//
// Usage
//   Input: drive cube_count and raise start; the item is taken at the rising
//   edge where start is high and busy is low. busy stays high while the
//   table is being filled and summed.
//   Output: stack_count is valid for exactly one cycle, marked by done. The
//   receiver cannot stall, so each result must be captured in that cycle.
// Throughput
//   One table term is read and accumulated per cycle; the single read port
//   of the table memory sets the pace. An item of n cubes (n >= 1) issues
//   R(n) fill terms and then n row-total terms, where R(n) is the number of
//   terms in the fill sums (sum over rows i = 3..n, columns j = 2..i-1 of
//   min(j, i-j)), about n^3/12. n = 0 (result 1) and n above MAX_N (result 0)
//   raise done in the cycle after acceptance without touching the table and
//   never raise busy.
// Reset
//   rst_n clears control state only. The table needs no clearing pass:
//   every entry read in an item is either a seeded one (first column or
//   diagonal, produced as 1 without a read) or was written earlier in the
//   same item.
`timescale 1ns / 1ps
`default_nettype none
module partition_count_dp_unit (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        start,
    input  wire logic [pcdp_pkg::IN_W-1:0]   cube_count,
    output logic                             busy,
    output logic                             done,
    output logic [pcdp_pkg::CNT_W-1:0]       stack_count
);

    logic            accept;
    logic            n_zero;
    logic            n_over;
    logic            go;
    pcdp_pkg::beat_t beat;
    pcdp_pkg::beat_t beat_q_reg;
    pcdp_pkg::cnt_t  rd_data;
    pcdp_pkg::cnt_t  term;
    pcdp_pkg::cnt_t  sum;
    pcdp_pkg::cnt_t  acc_reg, acc_next;
    pcdp_pkg::cnt_t  result_reg, result_next;
    logic            done_reg, done_next;
    logic            busy_reg, busy_next;
    logic            wr_en;

    assign accept = start && !busy_reg;
    assign n_zero = (cube_count == '0);
    assign n_over = (32'(cube_count) > pcdp_pkg::MAX_N);
    // Hand only counts that need the table to the sequencer
    assign go     = accept && !n_zero && !n_over;

    pcdp_seq u_seq (
        .clk   (clk),
        .rst_n (rst_n),
        .go    (go),
        .n_in  (pcdp_pkg::IDX_W'(cube_count)),
        .beat  (beat)
    );

    // Seeded terms need no read; the memory holds only computed entries
    pcdp_ram #(
        .WIDTH (pcdp_pkg::CNT_W),
        .DEPTH (pcdp_pkg::TABLE_DEPTH)
    ) u_table (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (beat_q_reg.wr_addr),
        .wr_data (sum),
        .rd_en   (beat.valid && !beat.seed),
        .rd_addr (beat.rd_addr),
        .rd_data (rd_data)
    );

    // Data phase: the issued beat registered, aligned with rd_data
    assign term  = beat_q_reg.seed ? pcdp_pkg::CNT_W'(1) : rd_data;
    assign sum   = (beat_q_reg.first ? '0 : acc_reg) + term;
    assign wr_en = beat_q_reg.valid && beat_q_reg.last && !beat_q_reg.final_sum;

    always_comb
    begin
        acc_next    = acc_reg;
        result_next = result_reg;
        done_next   = 1'b0;
        busy_next   = busy_reg;
        if (beat_q_reg.valid)
        begin
            acc_next = sum;
            if (beat_q_reg.last && beat_q_reg.final_sum)
            begin
                // Row total complete: present the item and drop busy
                result_next = sum;
                done_next   = 1'b1;
                busy_next   = 1'b0;
            end
        end
        if (accept)
        begin
            if (n_over)
            begin
                result_next = '0;
                done_next   = 1'b1;
            end
            else if (n_zero)
            begin
                result_next = pcdp_pkg::CNT_W'(1);
                done_next   = 1'b1;
            end
            else
            begin
                busy_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            beat_q_reg <= '0;
            done_reg   <= 1'b0;
            busy_reg   <= 1'b0;
        end
        else
        begin
            beat_q_reg <= beat;
            done_reg   <= done_next;
            busy_reg   <= busy_next;
        end
    end

    // Payload registers: no reset needed
    always_ff @(posedge clk)
    begin
        acc_reg    <= acc_next;
        result_reg <= result_next;
    end

    assign busy        = busy_reg;
    assign done        = done_reg;
    assign stack_count = result_reg;

    // Beats are issued only while an item is in the table
    a_beat_busy : assert property (@(posedge clk) disable iff (!rst_n)
        beat.valid |-> busy_reg)
        else $error("read beat issued while not busy");

    // A fill write never lands on the entry being read in the same cycle
    a_no_rw_clash : assert property (@(posedge clk) disable iff (!rst_n)
        (wr_en && beat.valid && !beat.seed) |-> (beat.rd_addr != beat_q_reg.wr_addr))
        else $error("table read and write clash on one entry");

    // Fill writes only go below the diagonal
    a_wr_below_diag : assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> (beat_q_reg.wr_addr[pcdp_pkg::IDX_W-1:0]
                   < beat_q_reg.wr_addr[pcdp_pkg::ADDR_W-1:pcdp_pkg::IDX_W]))
        else $error("fill write outside the lower triangle");

    // An accepted item either raises busy or is answered next cycle
    a_accept_resp : assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (busy_reg || done_reg))
        else $error("accepted item dropped");

endmodule
`default_nettype wire

### src/pcdp_ram.sv
// Generic simple dual-port RAM: one write port, one read port with a
// registered read. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module pcdp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule
`default_nettype wire

### src/pcdp_seq.sv
// Loop sequencer: walks the fill loops (row, column, term) and then the
// row-total loop, issuing one table read beat per cycle. Uses pcdp_pkg.
`timescale 1ns / 1ps
`default_nettype none
module pcdp_seq (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          go,
    input  wire pcdp_pkg::idx_t n_in,
    output pcdp_pkg::beat_t    beat
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_FILL,
        S_SUM
    } state_t;

    state_t         state_reg, state_next;
    pcdp_pkg::idx_t n_reg, n_next;
    pcdp_pkg::idx_t i_reg, i_next;
    pcdp_pkg::idx_t j_reg, j_next;
    pcdp_pkg::idx_t k_reg, k_next;
    pcdp_pkg::idx_t rest;
    pcdp_pkg::idx_t limit;
    logic           k_is_one;

    localparam pcdp_pkg::idx_t ONE = pcdp_pkg::IDX_W'(1);

    assign rest     = i_reg - j_reg;
    assign limit    = (j_reg < rest) ? j_reg : rest;
    assign k_is_one = (k_reg == ONE);

    // Current beat
    always_comb
    begin
        beat = '0;
        case (state_reg)
            S_FILL:
            begin
                beat.valid   = 1'b1;
                beat.rd_addr = {rest, k_reg};
                beat.seed    = k_is_one || (k_reg == rest);
                beat.first   = k_is_one;
                beat.last    = (k_reg == limit);
                beat.wr_addr = {i_reg, j_reg};
            end
            S_SUM:
            begin
                beat.valid     = 1'b1;
                beat.rd_addr   = {n_reg, k_reg};
                beat.seed      = k_is_one || (k_reg == n_reg);
                beat.first     = k_is_one;
                beat.last      = (k_reg == n_reg);
                beat.final_sum = 1'b1;
            end
            default:
            begin
                beat = '0;
            end
        endcase
    end

    // Advance the loop counters
    always_comb
    begin
        state_next = state_reg;
        n_next     = n_reg;
        i_next     = i_reg;
        j_next     = j_reg;
        k_next     = k_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (go)
                begin
                    n_next = n_in;
                    i_next = pcdp_pkg::IDX_W'(pcdp_pkg::FIRST_FILL_ROW);
                    j_next = pcdp_pkg::IDX_W'(pcdp_pkg::FIRST_FILL_COL);
                    k_next = ONE;
                    if (32'(n_in) >= 32'(pcdp_pkg::FIRST_FILL_ROW))
                    begin
                        state_next = S_FILL;
                    end
                    else
                    begin
                        state_next = S_SUM;
                    end
                end
            end
            S_FILL:
            begin
                if (k_reg == limit)
                begin
                    k_next = ONE;
                    if (j_reg == i_reg - ONE)
                    begin
                        j_next = pcdp_pkg::IDX_W'(pcdp_pkg::FIRST_FILL_COL);
                        if (i_reg == n_reg)
                        begin
                            state_next = S_SUM;
                        end
                        else
                        begin
                            i_next = i_reg + ONE;
                        end
                    end
                    else
                    begin
                        j_next = j_reg + ONE;
                    end
                end
                else
                begin
                    k_next = k_reg + ONE;
                end
            end
            S_SUM:
            begin
                if (k_reg == n_reg)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    k_next = k_reg + ONE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            n_reg     <= '0;
            i_reg     <= '0;
            j_reg     <= '0;
            k_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            n_reg     <= n_next;
            i_reg     <= i_next;
            j_reg     <= j_next;
            k_reg     <= k_next;
        end
    end

endmodule
`default_nettype wire
